### hdl/ipv4_fragment_header_gen_assert.svh
// assertion macros for the fragment header generator, used by ifhg_back
`ifndef IPV4_FRAGMENT_HEADER_GEN_ASSERT_SVH
`define IPV4_FRAGMENT_HEADER_GEN_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IFHG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IFHG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ifhg_pkg.sv
// types and constants of the ipv4 fragment header generator
`default_nettype none

package ifhg_pkg;

    // header constants
    localparam logic [13:0] HDR_LEN      = 14'd20;
    localparam logic [13:0] MTU_MIN      = 14'd576;
    localparam logic [13:0] MTU_MAX      = 14'd9000;
    localparam logic [13:0] MTU_RESET    = 14'd1500;
    localparam logic [15:0] VER_IHL_WORD = 16'h4500;
    localparam logic [15:0] TTL_WORD     = 16'h8000;

    // configuration register indexes
    localparam int unsigned    CFG_ADDR_W = 2;
    localparam logic [1:0]     REG_MTU    = 2'd0;
    localparam logic [1:0]     REG_SRC    = 2'd1;
    localparam logic [1:0]     REG_DST    = 2'd2;

    // small queues between and behind the two halves
    localparam logic [1:0] Q_DEPTH = 2'd2;

    // configuration seen by the datapath
    typedef struct packed {
        logic [13:0] mtu;
        logic [18:0] addr_sum;
    } cfg_t;

    // classified request handed from front to back
    typedef struct packed {
        logic [15:0] len;
        logic [7:0]  proto;
        logic [13:0] frag;
        logic [15:0] id;
        logic        too_long;
    } req_t;

    // one header description beat
    typedef struct packed {
        logic [13:0] total_length;
        logic [15:0] ident;
        logic        more_frags;
        logic [12:0] frag_offset;
        logic [15:0] header_sum;
        logic        too_long;
        logic        last_of_run;
    } res_t;

endpackage

`default_nettype wire

### hdl/ifhg_cfg.sv
// configuration registers and the constant part of the header checksum
`default_nettype none

module ifhg_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ifhg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [31:0]                      cfg_wdata,
    output ifhg_pkg::cfg_t                        cfg
);

    logic [13:0] mtu_reg;
    logic [31:0] src_reg;
    logic [31:0] dst_reg;
    logic [18:0] addr_sum_reg;
    logic [18:0] addr_sum_next;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg <= ifhg_pkg::MTU_RESET;
            src_reg <= '0;
            dst_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                ifhg_pkg::REG_MTU: mtu_reg <= cfg_wdata[13:0];
                ifhg_pkg::REG_SRC: src_reg <= cfg_wdata;
                ifhg_pkg::REG_DST: dst_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // words common to every header: version/ihl, ttl, both addresses
    assign addr_sum_next = 19'(ifhg_pkg::VER_IHL_WORD) + 19'(ifhg_pkg::TTL_WORD)
                         + 19'(src_reg[31:16]) + 19'(src_reg[15:0])
                         + 19'(dst_reg[31:16]) + 19'(dst_reg[15:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_sum_reg <= 19'(ifhg_pkg::VER_IHL_WORD) + 19'(ifhg_pkg::TTL_WORD);
        else
            addr_sum_reg <= addr_sum_next;
    end

    assign cfg.mtu      = mtu_reg;
    assign cfg.addr_sum = addr_sum_reg;

endmodule

`default_nettype wire

### hdl/ifhg_front.sv
// request intake: mtu clamp, size check, datagram id and request queue
`default_nettype none

module ifhg_front #(
    parameter int MAX_PAYLOAD = 16384
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [15:0]    payload_length,
    input  wire logic [7:0]     upper_protocol,
    input  wire logic [13:0]    mtu,
    input  wire logic           q_pop,
    output logic                q_valid,
    output ifhg_pkg::req_t      q_data
);

    localparam logic [16:0] MaxLen = 17'(MAX_PAYLOAD);

    logic [13:0]    mtu_sat;
    logic [13:0]    frag;
    logic [18:0]    frag_limit;
    logic           too_long;
    logic           accept;
    logic [15:0]    id_reg;
    ifhg_pkg::req_t req;

    ifhg_pkg::req_t q_mem [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    logic           do_pop;

    // clamp mtu and round the fragment payload down to a multiple of eight bytes
    always_comb
    begin
        if (mtu < ifhg_pkg::MTU_MIN)
            mtu_sat = ifhg_pkg::MTU_MIN;
        else if (mtu > ifhg_pkg::MTU_MAX)
            mtu_sat = ifhg_pkg::MTU_MAX;
        else
            mtu_sat = mtu;
        frag = (mtu_sat - ifhg_pkg::HDR_LEN) & ~14'd7;
    end

    // thirty fragments times the fragment size
    assign frag_limit = ({5'd0, frag} << 5) - ({5'd0, frag} << 1);
    assign too_long   = ({1'b0, payload_length} > MaxLen)
                     || ({3'd0, payload_length} > frag_limit);

    assign full   = (cnt_reg == ifhg_pkg::Q_DEPTH);
    assign accept = push && !full;

    // datagram id, only advanced by datagrams that are sent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            id_reg <= 16'd1;
        else if (accept && !too_long)
            id_reg <= id_reg + 16'd1;
    end

    always_comb
    begin
        req.len      = payload_length;
        req.proto    = upper_protocol;
        req.frag     = frag;
        req.id       = id_reg;
        req.too_long = too_long;
    end

    // two-entry request queue
    assign do_pop  = q_pop && (cnt_reg != 2'd0);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (accept)
            q_mem[wr_ptr_reg] <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (accept && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (!accept && do_pop)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

`default_nettype wire

### hdl/ifhg_back.sv
// fragment walker, checksum stage and result queue
`default_nettype none

`include "ipv4_fragment_header_gen_assert.svh"

module ifhg_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire ifhg_pkg::req_t q_data,
    output logic                q_pop,
    input  wire logic [18:0]    addr_sum,
    output ifhg_pkg::res_t      res,
    output logic                empty,
    input  wire logic           pop
);

    // walker state
    logic           busy_reg;
    logic [15:0]    remain_reg;
    logic [12:0]    off_reg;
    logic [13:0]    frag_size_reg;
    logic [15:0]    id_reg;
    logic [19:0]    dg_sum_reg;
    logic           tl_reg;

    // fragment stage
    logic           fv_reg;
    ifhg_pkg::res_t fres_reg;
    logic [19:0]    fsum_reg;

    // result queue
    ifhg_pkg::res_t o_mem [2];
    logic           owr_ptr_reg;
    logic           ord_ptr_reg;
    logic [1:0]     ocnt_reg;

    logic           load;
    logic           emit;
    logic           frag_ready;
    logic           fadv;
    logic           opop;
    logic           w_last;
    logic [15:0]    w_bytes;
    logic [13:0]    w_tot;
    ifhg_pkg::res_t w_res;
    logic [19:0]    s0;
    logic [16:0]    s1;
    logic [16:0]    s2;
    ifhg_pkg::res_t out_res;

    assign fadv       = fv_reg && (ocnt_reg != ifhg_pkg::Q_DEPTH);
    assign frag_ready = !fv_reg || fadv;
    assign emit       = busy_reg && frag_ready;
    assign load       = !busy_reg && q_valid;
    assign q_pop      = load;

    // next fragment from the walker
    always_comb
    begin
        w_last  = tl_reg || (remain_reg <= {2'd0, frag_size_reg});
        w_bytes = w_last ? remain_reg : {2'd0, frag_size_reg};
        w_tot   = w_bytes[13:0] + ifhg_pkg::HDR_LEN;
        w_res.total_length = tl_reg ? 14'd0 : w_tot;
        w_res.ident        = tl_reg ? 16'd0 : id_reg;
        w_res.more_frags   = !w_last;
        w_res.frag_offset  = tl_reg ? 13'd0 : off_reg;
        w_res.header_sum   = '0;
        w_res.too_long     = tl_reg;
        w_res.last_of_run  = w_last;
    end

    // walker: load a request, then one fragment per cycle while the fragment stage can advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (load)
            busy_reg <= 1'b1;
        else if (emit && w_last)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            remain_reg    <= q_data.len;
            off_reg       <= '0;
            frag_size_reg <= q_data.frag;
            id_reg        <= q_data.id;
            tl_reg        <= q_data.too_long;
            dg_sum_reg    <= 20'(addr_sum) + 20'(q_data.id) + 20'(q_data.proto);
        end
        else if (emit)
        begin
            remain_reg <= remain_reg - {2'd0, frag_size_reg};
            off_reg    <= off_reg + 13'(frag_size_reg[13:3]);
        end
    end

    // fragment stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (frag_ready)
            fv_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            fres_reg <= w_res;
            fsum_reg <= dg_sum_reg;
        end
    end

    // add length and flags/offset words, fold carries, complement (zero for refused beats)
    always_comb
    begin
        s0 = fsum_reg + 20'(fres_reg.total_length)
           + 20'({fres_reg.more_frags, fres_reg.frag_offset});
        s1 = 17'(s0[15:0]) + 17'(s0[19:16]);
        s2 = 17'(s1[15:0]) + 17'(s1[16]);
        out_res            = fres_reg;
        out_res.header_sum = fres_reg.too_long ? 16'd0 : ~s2[15:0];
    end

    // two-entry result queue
    assign opop  = pop && (ocnt_reg != 2'd0);
    assign empty = (ocnt_reg == 2'd0);
    assign res   = o_mem[ord_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (fadv)
            o_mem[owr_ptr_reg] <= out_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocnt_reg    <= 2'd0;
        end
        else
        begin
            if (fadv)
                owr_ptr_reg <= !owr_ptr_reg;
            if (opop)
                ord_ptr_reg <= !ord_ptr_reg;
            if (fadv && !opop)
                ocnt_reg <= ocnt_reg + 2'd1;
            else if (!fadv && opop)
                ocnt_reg <= ocnt_reg - 2'd1;
        end
    end

    // checks
    `IFHG_ASSERT_NEXT(a_run_ends, emit && w_last, !busy_reg, "walker busy after last fragment")
    `IFHG_ASSERT_NOW(a_mf_mid, fadv && !fres_reg.last_of_run, fres_reg.more_frags && !fres_reg.too_long, "middle fragment without more_frags")
    `IFHG_ASSERT_NEXT(a_frag_hold, fv_reg && !fadv, fv_reg && $stable(fres_reg), "stalled fragment changed")
    `IFHG_ASSERT_NOW(a_refused, fadv && fres_reg.too_long, fres_reg.last_of_run && (out_res.header_sum == 16'd0), "refused beat not final or nonzero")

endmodule

`default_nettype wire

### hdl/ipv4_fragment_header_gen.sv
// top level of the ipv4 fragment header generator
`default_nettype none

// Takes one datagram request (payload length, protocol) per push beat and
// emits one header description beat per fragment, with fragments of
// floor((mtu-20)/8)*8 payload bytes, a shared identification and the header
// checksum over the configured addresses. A request over MAX_PAYLOAD bytes
// or needing more than thirty fragments gives a single beat with too_long set.
// The fragment walker loads a request, then gives one header per cycle while
// the result path does not stall, and loads the next request only after the
// last header of its run. The front queue holds two requests, the result
// queue two beats, and a result passes the request queue, walker, fragment
// stage and result queue. Configuration writes are meant for idle.

module ipv4_fragment_header_gen #(
    parameter int MAX_PAYLOAD = 16384
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [ifhg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [31:0]                      cfg_wdata,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [15:0]                      payload_length,
    input  wire logic [7:0]                       upper_protocol,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [13:0]                           total_length,
    output logic [15:0]                           ident,
    output logic                                  more_frags,
    output logic [12:0]                           frag_offset,
    output logic [15:0]                           header_sum,
    output logic                                  too_long,
    output logic                                  last_of_run
);

    ifhg_pkg::cfg_t cfg;
    ifhg_pkg::req_t q_data;
    ifhg_pkg::res_t res;
    logic           q_valid;
    logic           q_pop;

    // configuration registers
    ifhg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // request intake and classification
    ifhg_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .payload_length (payload_length),
        .upper_protocol (upper_protocol),
        .mtu            (cfg.mtu),
        .q_pop          (q_pop),
        .q_valid        (q_valid),
        .q_data         (q_data)
    );

    // fragment generation
    ifhg_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .addr_sum (cfg.addr_sum),
        .res      (res),
        .empty    (empty),
        .pop      (pop)
    );

    // result fields
    assign total_length = res.total_length;
    assign ident        = res.ident;
    assign more_frags   = res.more_frags;
    assign frag_offset  = res.frag_offset;
    assign header_sum   = res.header_sum;
    assign too_long     = res.too_long;
    assign last_of_run  = res.last_of_run;

endmodule

`default_nettype wire
